FILE: hw/rtl/lrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and constants of the lineage rank-sum null sampler.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int U_W      = 17;
  localparam int V_W      = 18;
  localparam int RANK_W   = 17;
  localparam int SUM_W    = 40;
  localparam int DRAW_W   = 32;
  localparam int KIND_W   = 2;
  localparam int MODE_W   = 2;

  localparam int RECIP_BITS = 48;
  localparam int FRAC_BITS  = 32;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [KIND_W-1:0] KIND_COAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_U    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_V    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // mode zero behaves like the minus-one ratio
  localparam logic [MODE_W-1:0] MODE_ZERO  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLUS  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MINUS = 2'd2;
  localparam logic [MODE_W-1:0] MODE_EXACT = 2'd3;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_MINUS;

  typedef enum logic [1:0] {
    OP_COAL,
    OP_ADD_U,
    OP_ADD_V,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DRAW_W-1:0] draw;
    logic              last;
  } item_t;

endpackage

FILE: hw/rtl/lrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_front
// Input stage: takes events, decodes the kind into an operation, and hands
// them to the event queue.
// ----------------------------------------------------------------------------
module lrs_front
  import lrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [KIND_W-1:0] kind,
  input  logic [DRAW_W-1:0] uniform_draw,
  input  logic              end_of_run,
  output logic              q_push,
  output item_t             q_item,
  input  logic              q_full
);

  logic  hold_valid;
  item_t hold;
  logic  take;

  function automatic op_t classify(input logic [KIND_W-1:0] k);
    op_t o;
    case (k)
      KIND_COAL: o = OP_COAL;
      KIND_U:    o = OP_ADD_U;
      KIND_V:    o = OP_ADD_V;
      default:   o = OP_NONE;
    endcase
    return o;
  endfunction

  assign full   = hold_valid && q_full;
  assign take   = push && !full;
  assign q_push = hold_valid && !q_full;
  assign q_item = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (q_push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold.op   <= classify(kind);
      hold.draw <= uniform_draw;
      hold.last <= end_of_run;
    end
  end

endmodule

FILE: hw/rtl/lrs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_queue
// Small event queue between the front stage and the compute engine.
// ----------------------------------------------------------------------------
module lrs_queue
  import lrs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t din,
  output logic  full,
  input  logic  pop,
  output item_t dout,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("queue count beyond depth");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst) empty |-> rd_ptr == wr_ptr)
    else $error("queue empty with pointers apart");

endmodule

FILE: hw/rtl/lrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_back
// Compute engine: applies events to the lineage counts, works out the merge
// chance with a shared multiplier and a bit-serial divider, holds the result.
// ----------------------------------------------------------------------------
module lrs_back
  import lrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_empty,
  input  item_t             in_item,
  output logic              in_pop,
  input  logic              mode_we,
  input  logic [MODE_W-1:0] mode_wdata,
  output logic              empty,
  input  logic              pop,
  output logic [SUM_W-1:0]  rank_sum
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RLOAD,
    S_RDIV,
    S_MUL,
    S_FLOAD,
    S_FDIV,
    S_APPLY
  } state_t;

  localparam int CNT_W = $clog2(RECIP_BITS + 1);
  localparam int ACC_W = RECIP_BITS + 1;
  localparam int LO_W  = 25;

  state_t                    state;
  logic [MODE_W-1:0]         mode;
  logic [U_W-1:0]            u;
  logic signed [V_W-1:0]     v;
  logic [RANK_W-1:0]         rank;
  logic [SUM_W-1:0]          sum;
  op_t                       cur_op;
  logic [DRAW_W-1:0]         cur_draw;
  logic                      cur_last;
  logic                      hit;
  logic [2:0]                k;
  logic [1:0]                m;
  logic [63:0]               rem;
  logic [63:0]               dden;
  logic [RECIP_BITS-1:0]     quo;
  logic [CNT_W-1:0]          cnt;
  logic [RECIP_BITS-1:0]     common;
  logic [ACC_W-1:0]          acc1;
  logic [ACC_W-1:0]          acc2;
  logic [63:0]               fnum;
  logic [63:0]               fden;
  logic                      out_valid;
  logic [SUM_W-1:0]          out_data;

  logic [18:0]               zz;
  logic [18:0]               ww;
  logic [18:0]               ss;
  logic signed [19:0]        den12;
  logic [17:0]               num12;
  logic                      v_le1;
  logic [18:0]               mul_a;
  logic [LO_W-1:0]           mul_b;
  logic [43:0]               mul_p;
  logic [ACC_W-1:0]          acc_sel;
  logic [64:0]               shifted;
  logic [64:0]               diff;
  logic                      ge;
  logic [63:0]               rem_step;
  logic [RECIP_BITS-1:0]     quo_step;
  logic [SUM_W-1:0]          sum_new;

  assign zz    = {2'b00, u};
  assign ww    = {1'b0, v};
  assign ss    = zz + ww;
  assign v_le1 = v[V_W-1] || (v[V_W-2:0] <= 17'd1);
  assign num12 = (mode == MODE_PLUS) ? {1'b0, u} + 18'd1 : {1'b0, u} - 18'd1;
  assign den12 = $signed({3'b000, u}) + $signed({{2{v[V_W-1]}}, v})
               - ((mode == MODE_PLUS) ? 20'sd0 : 20'sd2);

  // one shared multiplier: reciprocal operands, then partial products
  assign acc_sel = m[1] ? acc2 : acc1;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_MUL) begin
      mul_a = m[1] ? ww - 19'd1 : zz - 19'd1;
      mul_b = m[0] ? {1'b0, acc_sel[ACC_W-1:LO_W]} : acc_sel[LO_W-1:0];
    end else begin
      case (k)
        3'd0: begin mul_a = ss - 19'd1; mul_b = {6'd0, ss - 19'd2}; end
        3'd1: begin mul_a = zz - 19'd1; mul_b = {6'd0, zz};         end
        3'd2: begin mul_a = ww;         mul_b = {6'd0, ww + 19'd1}; end
        3'd3: begin mul_a = ww - 19'd1; mul_b = {6'd0, ww};         end
        default: begin mul_a = zz;      mul_b = {6'd0, zz + 19'd1}; end
      endcase
    end
  end
  assign mul_p = {25'd0, mul_a} * {19'd0, mul_b};

  // restoring divider step, one quotient bit per cycle
  assign shifted  = {rem, 1'b0};
  assign diff     = shifted - {1'b0, dden};
  assign ge       = (shifted >= {1'b0, dden});
  assign rem_step = ge ? diff[63:0] : shifted[63:0];
  assign quo_step = {quo[RECIP_BITS-2:0], ge};

  assign sum_new = (cur_op == OP_COAL && hit) ? sum + {{(SUM_W-RANK_W){1'b0}}, rank} : sum;

  assign in_pop   = (state == S_IDLE) && !in_empty && !out_valid;
  assign empty    = !out_valid;
  assign rank_sum = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_RESET;
      u         <= '0;
      v         <= '0;
      rank      <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (mode_we) begin
        mode <= mode_wdata;
      end
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_pop) begin
            cur_op   <= in_item.op;
            cur_draw <= in_item.draw;
            cur_last <= in_item.last;
            if (in_item.op != OP_COAL) begin
              hit   <= 1'b0;
              state <= S_APPLY;
            end else begin
              rank <= rank + 1'b1;
              if (u <= 17'd1) begin
                hit   <= 1'b0;
                state <= S_APPLY;
              end else if (mode == MODE_EXACT) begin
                if (v_le1) begin
                  hit   <= 1'b1;
                  state <= S_APPLY;
                end else begin
                  k     <= 3'd0;
                  state <= S_RLOAD;
                end
              end else if (den12 == 20'sd0) begin
                hit   <= 1'b1;
                state <= S_APPLY;
              end else if (den12 < 20'sd0) begin
                hit   <= 1'b0;
                state <= S_APPLY;
              end else if ({2'b00, num12} >= den12[19:0]) begin
                hit   <= 1'b1;
                state <= S_APPLY;
              end else begin
                rem   <= {46'd0, num12};
                dden  <= {44'd0, den12[19:0]};
                quo   <= '0;
                cnt   <= CNT_W'(FRAC_BITS);
                state <= S_FDIV;
              end
            end
          end
        end
        S_RLOAD: begin
          dden  <= {20'd0, mul_p};
          rem   <= 64'd1;
          quo   <= '0;
          cnt   <= CNT_W'(RECIP_BITS);
          state <= S_RDIV;
        end
        S_RDIV: begin
          rem <= rem_step;
          quo <= quo_step;
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            case (k)
              3'd0: common <= quo_step;
              3'd1: acc1   <= {1'b0, quo_step - common};
              3'd2: acc1   <= acc1 + {1'b0, quo_step};
              3'd3: acc2   <= {1'b0, quo_step - common};
              default: acc2 <= acc2 + {1'b0, quo_step};
            endcase
            if (k == 3'd4) begin
              m     <= 2'd0;
              state <= S_MUL;
            end else begin
              k     <= k + 1'b1;
              state <= S_RLOAD;
            end
          end
        end
        S_MUL: begin
          m <= m + 1'b1;
          case (m)
            2'd0: fnum <= {20'd0, mul_p};
            2'd1: fnum <= fnum + ({20'd0, mul_p} << LO_W);
            2'd2: fden <= fnum + {20'd0, mul_p};
            default: begin
              fden  <= fden + ({20'd0, mul_p} << LO_W);
              state <= S_FLOAD;
            end
          endcase
        end
        S_FLOAD: begin
          if (fnum >= fden) begin
            hit   <= 1'b1;
            state <= S_APPLY;
          end else begin
            rem   <= fnum;
            dden  <= fden;
            quo   <= '0;
            cnt   <= CNT_W'(FRAC_BITS);
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          rem <= rem_step;
          quo <= quo_step;
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            hit   <= cur_draw < quo_step[FRAC_BITS-1:0];
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (cur_last) begin
            out_valid <= 1'b1;
            out_data  <= sum_new;
            u         <= '0;
            v         <= '0;
            rank      <= '0;
            sum       <= '0;
          end else begin
            case (cur_op)
              OP_ADD_U: u <= u + 1'b1;
              OP_ADD_V: v <= v + 18'sd1;
              OP_COAL: begin
                if (hit) begin
                  u <= u - 1'b1;
                end else begin
                  v <= v - 18'sd1;
                end
              end
              default: ;
            endcase
            sum <= sum_new;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_hit_needs_two: assert property (@(posedge clk) disable iff (rst)
      (state == S_APPLY && cur_op == OP_COAL && hit) |-> u > 17'd1)
    else $error("group u shrinks with fewer than two lineages");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
      (state == S_RDIV || state == S_FDIV) |-> cnt != '0)
    else $error("divider running with zero count");
  a_result_source: assert property (@(posedge clk) disable iff (rst)
      $rose(out_valid) |-> $past(state == S_APPLY && cur_last))
    else $error("result raised outside end of run");

endmodule

FILE: hw/rtl/lineage_ranksum_null_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lineage_ranksum_null_sampler
// Rank-sum sampler over coalescent tree events with three merge-chance forms.
//
//   channel  | handshake                  | payload
//   events   | push / full                | kind, uniform_draw, end_of_run
//   results  | empty / pop                | rank_sum
//   config   | probability_mode_we        | probability_mode
//
// Sample events and unknown kinds go straight from idle to the apply step.
// Coalescent events in forms 1 and 2 may run the bit-serial divider for the
// quotient; the exact form runs five reciprocals, four partial products, a
// compare and a 32-bit quotient.
// Reset clears all counts and the queue and sets the mode to 2.
// The engine starts an event only once the previous result has been popped;
// the input stage and queue keep accepting events meanwhile, until the queue fills.
// ----------------------------------------------------------------------------
module lineage_ranksum_null_sampler
  import lrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [KIND_W-1:0] kind,
  input  logic [DRAW_W-1:0] uniform_draw,
  input  logic              end_of_run,
  output logic              empty,
  input  logic              pop,
  output logic [SUM_W-1:0]  rank_sum,
  input  logic              probability_mode_we,
  input  logic [MODE_W-1:0] probability_mode
);

  logic  q_push;
  item_t q_din;
  logic  q_full;
  logic  q_pop;
  item_t q_dout;
  logic  q_empty;

  lrs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .uniform_draw (uniform_draw),
    .end_of_run   (end_of_run),
    .q_push       (q_push),
    .q_item       (q_din),
    .q_full       (q_full)
  );

  lrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  lrs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_empty   (q_empty),
    .in_item    (q_dout),
    .in_pop     (q_pop),
    .mode_we    (probability_mode_we),
    .mode_wdata (probability_mode),
    .empty      (empty),
    .pop        (pop),
    .rank_sum   (rank_sum)
  );

endmodule
